// File: hw/rtl/sssdd_pkg.sv
// Shared types and constants for the two-wire seven-segment display driver.
// Depends on nothing; imported by seven_segment_serial_display_driver.
`timescale 1ns / 1ps

package sssdd_pkg;

    localparam int VALUE_W     = 14;
    localparam int DIGITS_DEF  = 4;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int GAP_W       = 4;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_CONTROL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GAP_TICKS       = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DISPLAY_CONTROL_RST = 8'h8F;
    localparam logic [GAP_W-1:0]      GAP_TICKS_RST       = 4'd5;

    // Fixed bytes on the wire
    localparam logic [7:0] CMD_DATA_AUTO = 8'h40;
    localparam logic [7:0] CMD_ADDR_C0   = 8'hC0;

    // Item commands
    localparam logic CMD_SHOW = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic               command;
        logic [VALUE_W-1:0] value;
    } item_t;

    typedef struct packed {
        logic clk_level;
        logic dio_level;
        logic busy_res;
        logic accepted;
    } result_t;

    // Segment pattern for one decimal digit; non-decimal codes show blank
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] seg;
        case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

// File: hw/rtl/seven_segment_serial_display_driver.sv
// Two-wire seven-segment display driver: pin sequencer, decimal splitter,
// configuration registers and result skid buffer. Depends on sssdd_pkg.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                    payload
//  item      in         item_valid / item_stall      item   (command, value)
//  result    out        result_valid / result_stall  result (pins, busy, accepted)
//  cfg       in         cfg_we                       cfg_index, cfg_data
//
//  One item is taken per clock while item_stall is low; its result is registered
//  in the result register, or in the skid entry while that register is held.
//  Each tick moves the pin sequencer one step while a frame is active. A show
//  taken while idle starts a decimal split that peels one digit per cycle
//  with a reciprocal multiply in the background, ahead of any segment byte.
//  Reset (async, active low): idle, both pins high, digits zero.
//  The result side has a register plus one skid entry; item_stall rises only
//  while the skid entry is full.

module seven_segment_serial_display_driver #(
    parameter int DIGITS = sssdd_pkg::DIGITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   item_valid,
    output logic                                   item_stall,
    input  sssdd_pkg::item_t                       item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output sssdd_pkg::result_t                     result,
    input  logic                                   cfg_we,
    input  logic [sssdd_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [sssdd_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import sssdd_pkg::*;

    localparam int BCD_W    = 4 * DIGITS;
    localparam int CONV_W   = $clog2(DIGITS + 1);
    localparam int PROD_W   = VALUE_W + 16;
    localparam int RECIP_SH = 19;
    // 2^19 / 10 rounded up: exact quotient for every value that fits VALUE_W
    localparam logic [PROD_W-1:0] RECIP_10 = PROD_W'(52429);

    localparam logic [4:0] PH_IDLE    = 5'd0;
    localparam logic [4:0] PH_START1  = 5'd1;
    localparam logic [4:0] PH_START2  = 5'd2;
    localparam logic [4:0] PH_BITLOW  = 5'd3;
    localparam logic [4:0] PH_BITHIGH = 5'd4;
    localparam logic [4:0] PH_ACKLOW  = 5'd5;
    localparam logic [4:0] PH_ACKHIGH = 5'd6;
    localparam logic [4:0] PH_ACKEND  = 5'd7;
    localparam logic [4:0] PH_STOP1   = 5'd8;
    localparam logic [4:0] PH_STOP2   = 5'd9;
    localparam logic [4:0] PH_STOP3   = 5'd10;
    localparam logic [4:0] PH_GAP     = 5'd11;

    // Configuration
    logic [7:0]       display_control_reg;
    logic [GAP_W-1:0] gap_ticks_reg;

    // Sequencer state
    logic [4:0]       phase_reg, phase_next;
    logic [3:0]       bit_count_reg, bit_count_next;
    logic [2:0]       byte_count_reg, byte_count_next;
    logic [GAP_W-1:0] gap_count_reg, gap_count_next;
    logic [1:0]       frame_part_reg, frame_part_next;
    logic             clk_pin_reg, clk_pin_next;
    logic             dio_pin_reg, dio_pin_next;
    logic             active_reg, active_next;
    logic             taken;

    // Decimal split
    logic [BCD_W-1:0]   digit_reg, digit_next;
    logic [VALUE_W-1:0] value_sh_reg, value_sh_next;
    logic [CONV_W-1:0]  conv_cnt_reg, conv_cnt_next;
    logic [PROD_W-1:0]  conv_prod;
    logic [VALUE_W-1:0] conv_quo;
    logic [3:0]         conv_rem;
    logic               start_conv;

    // Result buffer
    logic    result_valid_reg, result_valid_next;
    result_t result_reg, result_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t skid_reg;
    result_t step_res;

    logic       item_acc;
    logic       result_take;
    logic [7:0] cur_byte;
    logic [3:0] sel_digit;
    logic       last_byte;

    assign item_stall   = skid_valid_reg;
    assign item_acc     = item_valid && !skid_valid_reg;
    assign result_take  = result_valid_reg && !result_stall;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Byte on the wire for the current frame and byte position
    always_comb
    begin
        sel_digit = digit_reg[3:0];
        for (int i = 0; i < DIGITS; i++)
        begin
            if (byte_count_reg == 3'(DIGITS - i))
            begin
                sel_digit = digit_reg[4*i +: 4];
            end
        end
        if (frame_part_reg == 2'd0)
        begin
            cur_byte = CMD_DATA_AUTO;
        end
        else if (frame_part_reg == 2'd2)
        begin
            cur_byte = display_control_reg;
        end
        else if (byte_count_reg == 3'd0)
        begin
            cur_byte = CMD_ADDR_C0;
        end
        else
        begin
            cur_byte = seg_code(sel_digit);
        end
        last_byte = (frame_part_reg == 2'd1) ? (byte_count_reg >= 3'(DIGITS)) : 1'b1;
    end

    // One step per accepted tick while active; a show while idle starts a frame
    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        byte_count_next = byte_count_reg;
        gap_count_next  = gap_count_reg;
        frame_part_next = frame_part_reg;
        clk_pin_next    = clk_pin_reg;
        dio_pin_next    = dio_pin_reg;
        active_next     = active_reg;
        taken           = 1'b0;
        start_conv      = 1'b0;

        if (item_acc && item.command == CMD_SHOW && !active_reg)
        begin
            active_next     = 1'b1;
            frame_part_next = 2'd0;
            byte_count_next = 3'd0;
            bit_count_next  = 4'd0;
            gap_count_next  = '0;
            phase_next      = PH_START1;
            taken           = 1'b1;
            start_conv      = 1'b1;
        end
        else if (item_acc && item.command == CMD_TICK && active_reg)
        begin
            case (phase_reg)
                PH_START1:
                begin
                    clk_pin_next = 1'b1;
                    dio_pin_next = 1'b1;
                    phase_next   = PH_START2;
                end
                PH_START2:
                begin
                    dio_pin_next   = 1'b0;
                    bit_count_next = 4'd0;
                    phase_next     = PH_BITLOW;
                end
                PH_BITLOW:
                begin
                    clk_pin_next = 1'b0;
                    dio_pin_next = cur_byte[bit_count_reg[2:0]];
                    phase_next   = PH_BITHIGH;
                end
                PH_BITHIGH:
                begin
                    clk_pin_next   = 1'b1;
                    bit_count_next = bit_count_reg + 4'd1;
                    phase_next     = (bit_count_next >= 4'd8) ? PH_ACKLOW : PH_BITLOW;
                end
                PH_ACKLOW:
                begin
                    clk_pin_next = 1'b0;
                    dio_pin_next = 1'b1;
                    phase_next   = PH_ACKHIGH;
                end
                PH_ACKHIGH:
                begin
                    clk_pin_next = 1'b1;
                    phase_next   = PH_ACKEND;
                end
                PH_ACKEND:
                begin
                    clk_pin_next   = 1'b0;
                    bit_count_next = 4'd0;
                    if (last_byte)
                    begin
                        phase_next = PH_STOP1;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg + 3'd1;
                        phase_next      = PH_BITLOW;
                    end
                end
                PH_STOP1:
                begin
                    clk_pin_next = 1'b0;
                    dio_pin_next = 1'b0;
                    phase_next   = PH_STOP2;
                end
                PH_STOP2:
                begin
                    clk_pin_next = 1'b1;
                    phase_next   = PH_STOP3;
                end
                PH_STOP3:
                begin
                    dio_pin_next = 1'b1;
                    if (frame_part_reg >= 2'd2)
                    begin
                        phase_next      = PH_IDLE;
                        active_next     = 1'b0;
                        frame_part_next = 2'd0;
                        byte_count_next = 3'd0;
                    end
                    else if (gap_ticks_reg == '0)
                    begin
                        frame_part_next = frame_part_reg + 2'd1;
                        byte_count_next = 3'd0;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_START1;
                    end
                    else
                    begin
                        gap_count_next = gap_ticks_reg;
                        phase_next     = PH_GAP;
                    end
                end
                PH_GAP:
                begin
                    gap_count_next = gap_count_reg - GAP_W'(1);
                    if (gap_count_next == '0)
                    begin
                        frame_part_next = frame_part_reg + 2'd1;
                        byte_count_next = 3'd0;
                        bit_count_next  = 4'd0;
                        phase_next      = PH_START1;
                    end
                end
                default:
                begin
                    phase_next   = PH_IDLE;
                    active_next  = 1'b0;
                    clk_pin_next = 1'b1;
                    dio_pin_next = 1'b1;
                end
            endcase
        end

        step_res.clk_level = clk_pin_next;
        step_res.dio_level = dio_pin_next;
        step_res.busy_res  = active_next;
        step_res.accepted  = taken;
    end

    // Peel one decimal digit per cycle, ones first; the quotient feeds back
    always_comb
    begin
        digit_next    = digit_reg;
        value_sh_next = value_sh_reg;
        conv_cnt_next = conv_cnt_reg;
        conv_prod     = PROD_W'(value_sh_reg) * RECIP_10;
        conv_quo      = VALUE_W'(conv_prod >> RECIP_SH);
        conv_rem      = 4'(value_sh_reg - conv_quo * VALUE_W'(10));
        if (start_conv)
        begin
            digit_next    = '0;
            value_sh_next = item.value;
            conv_cnt_next = CONV_W'(DIGITS);
        end
        else if (conv_cnt_reg != '0)
        begin
            for (int i = 0; i < DIGITS; i++)
            begin
                if (conv_cnt_reg == CONV_W'(DIGITS - i))
                begin
                    digit_next[4*i +: 4] = conv_rem;
                end
            end
            value_sh_next = conv_quo;
            conv_cnt_next = conv_cnt_reg - CONV_W'(1);
        end
    end

    // Result register and skid entry
    always_comb
    begin
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        skid_valid_next   = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (result_take)
            begin
                result_next     = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (item_acc)
        begin
            if (!result_valid_reg || result_take)
            begin
                result_next       = step_res;
                result_valid_next = 1'b1;
            end
            else
            begin
                skid_valid_next = 1'b1;
            end
        end
        else if (result_take)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            display_control_reg <= DISPLAY_CONTROL_RST;
            gap_ticks_reg       <= GAP_TICKS_RST;
            phase_reg           <= PH_IDLE;
            bit_count_reg       <= 4'd0;
            byte_count_reg      <= 3'd0;
            gap_count_reg       <= '0;
            frame_part_reg      <= 2'd0;
            clk_pin_reg         <= 1'b1;
            dio_pin_reg         <= 1'b1;
            active_reg          <= 1'b0;
            digit_reg           <= '0;
            conv_cnt_reg        <= '0;
            result_valid_reg    <= 1'b0;
            skid_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we && cfg_index == CFG_DISPLAY_CONTROL)
            begin
                display_control_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == CFG_GAP_TICKS)
            begin
                gap_ticks_reg <= cfg_data[GAP_W-1:0];
            end
            phase_reg        <= phase_next;
            bit_count_reg    <= bit_count_next;
            byte_count_reg   <= byte_count_next;
            gap_count_reg    <= gap_count_next;
            frame_part_reg   <= frame_part_next;
            clk_pin_reg      <= clk_pin_next;
            dio_pin_reg      <= dio_pin_next;
            active_reg       <= active_next;
            digit_reg        <= digit_next;
            conv_cnt_reg     <= conv_cnt_next;
            result_valid_reg <= result_valid_next;
            skid_valid_reg   <= skid_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        value_sh_reg <= value_sh_next;
        result_reg   <= result_next;
        if (!skid_valid_reg && item_acc && result_valid_reg && !result_take)
        begin
            skid_reg <= step_res;
        end
    end

    // The decimal split must be done before any segment byte is put on the wire
    assert property (@(posedge clk) disable iff (!rst_n)
        (conv_cnt_reg != '0) |->
        !(phase_reg == PH_BITLOW && frame_part_reg == 2'd1 && byte_count_reg != 3'd0))
        else $error("segment byte read while decimal split in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> result_valid_reg)
        else $error("skid entry held with empty result register");

    assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (clk_pin_reg && dio_pin_reg && phase_reg == PH_IDLE))
        else $error("pins not released while idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.accepted) |-> result_reg.busy_res)
        else $error("accepted show without busy");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for seven_segment_serial_display_driver: drives show and tick
// transactions with bursty traffic, predicts the pin sequence and checks every result.
// Depends on sssdd_pkg and the driver RTL.
`timescale 1ns / 1ps

module tb_top;

    import sssdd_pkg::*;

    localparam int DIGITS = DIGITS_DEF;

    // Register indexes that map to no register
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE, S_START_HI, S_START_LO, S_BIT_LO, S_BIT_HI, S_ACK_LO, S_ACK_HI,
        S_ACK_END, S_STOP_LO, S_STOP_HI, S_STOP_END, S_GAP
    } seq_phase_e;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall;
    result_t                result;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Pin sequencer model state
    logic [7:0]       ctl_reg;
    logic [GAP_W-1:0] gap_ticks_reg;
    logic [3:0]       digit_q [DIGITS];
    seq_phase_e       phase_q;
    logic [3:0]       bit_q;
    logic [2:0]       byte_q;
    logic [3:0]       gap_left;
    logic [1:0]       frame_q;
    logic             clk_q;
    logic             dio_q;
    logic             busy_q;
    logic [7:0]       seg_lut [16];

    result_t pin_results_q [$];
    result_t want_r;
    int      error_count;

    // Traffic shaping knobs
    int gap_max_c;
    int burst_max_c;
    int stall_pct;
    int burst_left;
    int stall_run;
    logic stall_level;

    seven_segment_serial_display_driver i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        seg_lut = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
                    8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
    end

    function automatic item_t pack_item(input logic cmd, input logic [VALUE_W-1:0] val);
        item_t it;
        it.command = cmd;
        it.value   = val;
        return it;
    endfunction

    function automatic logic [7:0] wire_byte();
        int idx;
        if (frame_q == 2'd0)
            return CMD_DATA_AUTO;
        if (frame_q == 2'd2)
            return ctl_reg;
        if (byte_q == 3'd0)
            return CMD_ADDR_C0;
        idx = (byte_q <= DIGITS) ? DIGITS - byte_q : 0;
        return seg_lut[digit_q[idx]];
    endfunction

    task automatic begin_frame();
        frame_q = frame_q + 2'd1;
        byte_q  = '0;
        bit_q   = '0;
        phase_q = S_START_HI;
    endtask

    task automatic step_sequencer();
        logic [7:0] cur;
        case (phase_q)
            S_START_HI:
            begin
                clk_q = 1'b1; dio_q = 1'b1; phase_q = S_START_LO;
            end
            S_START_LO:
            begin
                dio_q = 1'b0; bit_q = '0; phase_q = S_BIT_LO;
            end
            S_BIT_LO:
            begin
                clk_q = 1'b0;
                cur = wire_byte();
                dio_q = cur[bit_q[2:0]];
                phase_q = S_BIT_HI;
            end
            S_BIT_HI:
            begin
                clk_q = 1'b1;
                bit_q = bit_q + 4'd1;
                phase_q = (bit_q >= 4'd8) ? S_ACK_LO : S_BIT_LO;
            end
            S_ACK_LO:
            begin
                clk_q = 1'b0; dio_q = 1'b1; phase_q = S_ACK_HI;
            end
            S_ACK_HI:
            begin
                clk_q = 1'b1; phase_q = S_ACK_END;
            end
            S_ACK_END:
            begin
                clk_q = 1'b0;
                bit_q = '0;
                if (frame_q != 2'd1 || byte_q >= DIGITS)
                    phase_q = S_STOP_LO;
                else
                begin
                    byte_q = byte_q + 3'd1;
                    phase_q = S_BIT_LO;
                end
            end
            S_STOP_LO:
            begin
                clk_q = 1'b0; dio_q = 1'b0; phase_q = S_STOP_HI;
            end
            S_STOP_HI:
            begin
                clk_q = 1'b1; phase_q = S_STOP_END;
            end
            S_STOP_END:
            begin
                dio_q = 1'b1;
                if (frame_q >= 2'd2)
                begin
                    phase_q = S_IDLE;
                    busy_q  = 1'b0;
                    frame_q = '0;
                    byte_q  = '0;
                end
                else if (gap_ticks_reg == '0)
                    begin_frame();
                else
                begin
                    gap_left = gap_ticks_reg;
                    phase_q  = S_GAP;
                end
            end
            S_GAP:
            begin
                gap_left = gap_left - 4'd1;
                if (gap_left == '0)
                    begin_frame();
            end
            default:
            begin
                phase_q = S_IDLE; busy_q = 1'b0; clk_q = 1'b1; dio_q = 1'b1;
            end
        endcase
    endtask

    // Advance the model by one accepted transaction and queue its result
    task automatic predict_pins(input item_t it);
        result_t r;
        int v;
        int i;
        r.accepted = 1'b0;
        if (it.command == CMD_SHOW)
        begin
            if (!busy_q)
            begin
                v = int'(it.value);
                for (i = 0; i < DIGITS; i++)
                begin
                    digit_q[i] = 4'(v % 10);
                    v = v / 10;
                end
                busy_q   = 1'b1;
                frame_q  = '0;
                byte_q   = '0;
                bit_q    = '0;
                gap_left = '0;
                phase_q  = S_START_HI;
                r.accepted = 1'b1;
            end
        end
        else if (busy_q)
            step_sequencer();
        r.clk_level = clk_q;
        r.dio_level = dio_q;
        r.busy_res  = busy_q;
        pin_results_q.push_back(r);
    endtask

    task automatic reset_model();
        int i;
        ctl_reg       = DISPLAY_CONTROL_RST;
        gap_ticks_reg = GAP_TICKS_RST;
        for (i = 0; i < DIGITS; i++)
            digit_q[i] = '0;
        phase_q  = S_IDLE;
        bit_q    = '0;
        byte_q   = '0;
        gap_left = '0;
        frame_q  = '0;
        clk_q    = 1'b1;
        dio_q    = 1'b1;
        busy_q   = 1'b0;
    endtask

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            if (error_count < 100)
                $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pin_results_q.size() == 0)
            begin
                if (error_count < 100)
                    $display("%0t: unexpected result: expected none, actual %b", $time, result);
                error_count++;
            end
            else
            begin
                want_r = pin_results_q.pop_front();
                check_bit("clk_level", want_r.clk_level, result.clk_level);
                check_bit("dio_level", want_r.dio_level, result.dio_level);
                check_bit("busy_res", want_r.busy_res, result.busy_res);
                check_bit("accepted", want_r.accepted, result.accepted);
            end
        end
    end

    // Receiver stalls in runs of random length
    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_level = ($urandom_range(0, 99) < stall_pct);
            stall_run   = $urandom_range(1, 6);
        end
        stall_run--;
        result_stall <= stall_level;
    end

    // Send one transaction; valid stays high while a burst goes on
    task automatic send_item(input item_t it);
        int pause;
        if (burst_left == 0)
        begin
            pause = (gap_max_c == 0) ? 0 : $urandom_range(0, gap_max_c);
            if (pause != 0)
            begin
                item_valid <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            burst_left = $urandom_range(1, burst_max_c);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        predict_pins(it);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic tick_once();
        send_item(pack_item(CMD_TICK, VALUE_W'($urandom_range(0, 16383))));
    endtask

    task automatic show_value(input logic [VALUE_W-1:0] val);
        send_item(pack_item(CMD_SHOW, val));
    endtask

    task automatic run_frame();
        while (busy_q)
            tick_once();
    endtask

    // Drop valid and wait until every queued result has come back
    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (pin_results_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_DISPLAY_CONTROL)
            ctl_reg = data;
        else if (idx == CFG_GAP_TICKS)
            gap_ticks_reg = data[GAP_W-1:0];
    endtask

    task automatic test_idle_ticks();
        repeat (3) tick_once();
        settle();
    endtask

    task automatic test_extreme_values();
        write_reg(CFG_GAP_TICKS, 8'd0);
        write_reg(CFG_DISPLAY_CONTROL, 8'h00);
        show_value(VALUE_W'(16383));
        run_frame();
        settle();
        write_reg(CFG_GAP_TICKS, 8'd15);
        write_reg(CFG_DISPLAY_CONTROL, 8'hFF);
        show_value(VALUE_W'(9999));
        run_frame();
        settle();
    endtask

    task automatic test_show_while_busy();
        show_value(VALUE_W'(1234));
        repeat (30) tick_once();
        show_value(VALUE_W'(8765));
        tick_once();
        show_value(VALUE_W'(10000));
        run_frame();
        show_value(VALUE_W'(10000));
        run_frame();
        settle();
    endtask

    task automatic test_spare_index();
        write_reg(CFG_SPARE_2, 8'hFF);
        write_reg(CFG_SPARE_3, 8'h00);
        show_value(VALUE_W'(5050));
        run_frame();
        settle();
    endtask

    task automatic test_midframe_config();
        write_reg(CFG_GAP_TICKS, 8'd7);
        show_value(VALUE_W'(4321));
        while (phase_q != S_GAP)
            tick_once();
        tick_once();
        settle();
        // the running gap keeps its count, the next one uses the new value
        write_reg(CFG_GAP_TICKS, 8'd1);
        repeat (40) tick_once();
        settle();
        write_reg(CFG_DISPLAY_CONTROL, 8'h5A);
        run_frame();
        settle();
    endtask

    // Mostly complete frames with random values; ignored shows and idle ticks as noise
    task automatic test_random_traffic(input int n_items);
        int done_cnt;
        item_t it;
        done_cnt = 0;
        while (done_cnt < n_items)
        begin
            if (!busy_q)
                it.command = ($urandom_range(0, 9) < 8) ? CMD_SHOW : CMD_TICK;
            else
                it.command = ($urandom_range(0, 39) == 0) ? CMD_SHOW : CMD_TICK;
            it.value = VALUE_W'($urandom_range(0, 16383));
            if (busy_q == (it.command == CMD_TICK))
                done_cnt++;
            send_item(it);
        end
        settle();
    endtask

    initial
    begin
        int p;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        result_stall = 1'b0;
        stall_run    = 0;
        stall_level  = 1'b0;
        burst_left   = 0;
        error_count  = 0;
        gap_max_c    = 4;
        burst_max_c  = 12;
        stall_pct    = 30;
        reset_model();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_idle_ticks();
        test_extreme_values();
        test_show_while_busy();
        test_spare_index();
        test_midframe_config();

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    write_reg(CFG_GAP_TICKS, 8'd0);
                    write_reg(CFG_DISPLAY_CONTROL, 8'h00);
                    gap_max_c = 0; burst_max_c = 1; stall_pct = 0;
                end
                1:
                begin
                    write_reg(CFG_GAP_TICKS, 8'd15);
                    write_reg(CFG_DISPLAY_CONTROL, 8'hFF);
                    gap_max_c = 8; burst_max_c = 4; stall_pct = 70;
                end
                default:
                begin
                    write_reg(CFG_GAP_TICKS, 8'($urandom_range(0, 15)));
                    write_reg(CFG_DISPLAY_CONTROL, 8'($urandom_range(0, 255)));
                    gap_max_c = $urandom_range(0, 6);
                    burst_max_c = $urandom_range(1, 20);
                    stall_pct = $urandom_range(0, 60);
                end
            endcase
            test_random_traffic(30);
        end

        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/sssdd_pkg.sv
hw/rtl/seven_segment_serial_display_driver.sv
sim/tb_top.sv
